// File: hdl/rolling_percentile_rank_regime_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rolling percentile rank regime block
// Shared wrappers so every check uses the same clock and reset qualification.
// ----------------------------------------------------------------------------
`ifndef ROLLING_PERCENTILE_RANK_REGIME_ASSERT_SVH
`define ROLLING_PERCENTILE_RANK_REGIME_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define RPRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must never be seen outside of reset.
`define RPRR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hdl/rprr_pkg.sv
// ----------------------------------------------------------------------------
// Rolling percentile rank regime package
// Widths, register indexes and regime codes shared by the block's modules.
// ----------------------------------------------------------------------------
package rprr_pkg;

  // Window length register width; also bounds the prior-sample count.
  localparam int WIN_W  = 9;
  // Percent in Q8 fixed point (0..25600).
  localparam int PCT_W  = 15;
  // Product of a percent value and a count: 15 x 9 bits.
  localparam int PROD_W = PCT_W + WIN_W;
  // Configuration index width.
  localparam int CFG_IDX_W = 2;

  localparam logic [PCT_W-1:0] RANK_FULL = PCT_W'(25600);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LO_PCT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HI_PCT     = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_LEN_RST = WIN_W'(250);
  localparam logic [PCT_W-1:0] LO_PCT_RST     = PCT_W'(7680);
  localparam logic [PCT_W-1:0] HI_PCT_RST     = PCT_W'(17920);

  typedef enum logic [1:0] {
    REGIME_CALM     = 2'd0,
    REGIME_NORMAL   = 2'd1,
    REGIME_VOLATILE = 2'd2
  } regime_t;

endpackage

// File: hdl/rprr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rprr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rprr_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle for the rank division.
// ----------------------------------------------------------------------------
module rprr_div
  import rprr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [WIN_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;
  logic [WIN_W-1:0]  dsr_r, dsr_nxt;
  logic [WIN_W:0]    trial;

  // The remainder stays below the divisor, so one extra bit holds the trial.
  assign trial = {rem_r, quo_r[PROD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(PROD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = WIN_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIN_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/rolling_percentile_rank_regime.sv
// ----------------------------------------------------------------------------
// Rolling percentile rank regime classifier
// Ranks each sample among the previous window-1 samples and labels the regime.
// ----------------------------------------------------------------------------
// Usage: each word on the input channel (in_valid, in_stall, in_sample) is one
// volatility sample. The block answers every word with exactly one result word
// on the output channel (out_valid, out_stall, out_rank_q8, out_regime,
// out_window_full). The window length and the two thresholds are written over
// the cfg_ channel, which is always ready outside of reset; write them only
// while no sample is in flight.
// Processing: after acceptance a sample goes through a scan of the history RAM
// (W - 1 reads, the registered read and a closing step, W being the effective
// window length), the scaled count and the calm product on the shared
// multiplier, the serial divider running its 24 steps and flagging completion,
// and the load of the output register. in_stall stays high from acceptance
// until that load, so a new sample is taken only once the last is through.
// Reset: the history is treated as all zero, the write slot and fill count go
// to zero and the registers take their reset values. No clearing pass is
// needed because a slot at or above the fill count reads as zero.
// Output stall: the result sits in an output register. A new sample is taken
// while a result waits, but the next result is held back until it is taken.
// ----------------------------------------------------------------------------
`include "rolling_percentile_rank_regime_assert.svh"

module rolling_percentile_rank_regime
  import rprr_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PCT_W-1:0]       out_rank_q8,
  output logic [1:0]             out_regime,
  output logic                   out_window_full,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PCT_W-1:0]       cfg_data
);

  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_MAX - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL_SC,
    S_MUL_LO,
    S_MUL_HI,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [WIN_W-1:0] window_len_r;
  logic [PCT_W-1:0] lo_pct_r;
  logic [PCT_W-1:0] hi_pct_r;

  // Ring buffer bookkeeping. A slot below the fill count has been written.
  logic [PW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  // Per-sample working registers.
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [WIN_W-1:0]       prior_r, prior_nxt;
  logic [WIN_W-1:0]       rem_r, rem_nxt;
  logic [PW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic                   pend_r, pend_nxt;
  logic                   pend_wr_r, pend_wr_nxt;
  logic [WIN_W-1:0]       count_r, count_nxt;
  logic [PROD_W-1:0]      scaled_r, scaled_nxt;
  logic [PROD_W-1:0]      lo_prod_r, lo_prod_nxt;
  regime_t                regime_r, regime_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0] rank_out_r, rank_out_nxt;
  regime_t          regime_out_r, regime_out_nxt;
  logic             full_out_r, full_out_nxt;

  logic [WIN_W-1:0]       weff;
  logic [SAMPLE_BITS-1:0] ram_q;
  logic [SAMPLE_BITS-1:0] hist_val;
  logic                   hit;
  logic                   ram_we;
  logic [PCT_W-1:0]       mul_a;
  logic [WIN_W-1:0]       mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic                   div_start;
  logic                   div_done;
  logic [PROD_W-1:0]      div_quo;
  logic                   in_take;
  logic                   out_free;

  // Clamp the window to 2..WINDOW_MAX so the divisor is never zero.
  always_comb begin
    if (window_len_r < WIN_W'(2)) begin
      weff = WIN_W'(2);
    end else if (32'(window_len_r) > WINDOW_MAX) begin
      weff = WIN_W'(WINDOW_MAX);
    end else begin
      weff = window_len_r;
    end
  end

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = rst_n;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // History store; written once per sample at the end of its processing.
  rprr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sample_r),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  // Slots that were never written read as zero.
  assign hist_val = pend_wr_r ? ram_q : '0;
  assign hit      = pend_r && (hist_val < sample_r);

  // One multiplier serves the rank scaling and both threshold products.
  always_comb begin
    unique case (state_r)
      S_MUL_LO: begin
        mul_a = lo_pct_r;
        mul_b = prior_r;
      end
      S_MUL_HI: begin
        mul_a = hi_pct_r;
        mul_b = prior_r;
      end
      default: begin
        mul_a = RANK_FULL;
        mul_b = count_r;
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  rprr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scaled_r),
    .divisor  (prior_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    sample_nxt     = sample_r;
    prior_nxt      = prior_r;
    rem_nxt        = rem_r;
    rd_ptr_nxt     = rd_ptr_r;
    pend_nxt       = pend_r;
    pend_wr_nxt    = pend_wr_r;
    count_nxt      = count_r;
    scaled_nxt     = scaled_r;
    lo_prod_nxt    = lo_prod_r;
    regime_nxt     = regime_r;
    out_valid_nxt  = out_valid_r;
    rank_out_nxt   = rank_out_r;
    regime_out_nxt = regime_out_r;
    full_out_nxt   = full_out_r;
    ram_we         = 1'b0;
    div_start      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          sample_nxt = in_sample;
          prior_nxt  = weff - 1'b1;
          rem_nxt    = weff - 1'b1;
          rd_ptr_nxt = (wp_r == '0) ? PTR_LAST : wp_r - 1'b1;
          pend_nxt   = 1'b0;
          count_nxt  = '0;
          state_nxt  = S_SCAN;
        end
      end
      // Walk back from the newest stored sample, one read per cycle; the
      // compare uses the registered read data in the cycle after its address.
      S_SCAN: begin
        if (hit) begin
          count_nxt = count_r + 1'b1;
        end
        if (rem_r != '0) begin
          rem_nxt     = rem_r - 1'b1;
          rd_ptr_nxt  = (rd_ptr_r == '0) ? PTR_LAST : rd_ptr_r - 1'b1;
          pend_nxt    = 1'b1;
          pend_wr_nxt = FW'(rd_ptr_r) < fill_r;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_MUL_SC;
          end
        end
      end
      S_MUL_SC: begin
        scaled_nxt = mul_p;
        state_nxt  = S_MUL_LO;
      end
      S_MUL_LO: begin
        lo_prod_nxt = mul_p;
        div_start   = 1'b1;
        state_nxt   = S_MUL_HI;
      end
      // The calm test wins when the thresholds cross.
      S_MUL_HI: begin
        if (scaled_r < lo_prod_r) begin
          regime_nxt = REGIME_CALM;
        end else if (scaled_r > mul_p) begin
          regime_nxt = REGIME_VOLATILE;
        end else begin
          regime_nxt = REGIME_NORMAL;
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          rank_out_nxt   = div_quo[PCT_W-1:0];
          regime_out_nxt = regime_r;
          full_out_nxt   = 32'(fill_r) >= 32'(prior_r);
          ram_we         = 1'b1;
          wp_nxt         = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
          if (fill_r != FILL_MAX) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      count_r      <= '0;
      prior_r      <= WIN_W'(1);
      window_len_r <= WINDOW_LEN_RST;
      lo_pct_r     <= LO_PCT_RST;
      hi_pct_r     <= HI_PCT_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      prior_r     <= prior_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WINDOW_LEN: window_len_r <= cfg_data[WIN_W-1:0];
          CFG_LO_PCT:     lo_pct_r     <= cfg_data;
          CFG_HI_PCT:     hi_pct_r     <= cfg_data;
          default:        ;
        endcase
      end
    end
    sample_r     <= sample_nxt;
    rem_r        <= rem_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    pend_wr_r    <= pend_wr_nxt;
    scaled_r     <= scaled_nxt;
    lo_prod_r    <= lo_prod_nxt;
    regime_r     <= regime_nxt;
    rank_out_r   <= rank_out_nxt;
    regime_out_r <= regime_out_nxt;
    full_out_r   <= full_out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rank_q8     = rank_out_r;
  assign out_regime      = regime_out_r;
  assign out_window_full = full_out_r;

  // An accepted sample always starts the history scan.
  `RPRR_ASSERT(a_take_starts_scan, in_take |=> state_r == S_SCAN, "accepted sample did not start scan")
  // The count of smaller samples can never exceed the samples compared.
  `RPRR_ASSERT(a_count_bounded, count_r <= prior_r, "rank count exceeds prior samples")
  // The fill count saturates at the history depth.
  `RPRR_ASSERT(a_fill_bounded, fill_r <= FILL_MAX, "fill count above history depth")
  // A calm label implies the floored rank lies below the calm threshold.
  `RPRR_ASSERT(a_calm_rank, out_valid_r && out_regime == REGIME_CALM |-> out_rank_q8 < lo_pct_r, "calm result with rank at or above threshold")
  // The history is written only when a result is handed to the output register.
  `RPRR_ASSERT_NEVER(a_write_only_done, ram_we && state_r != S_DONE, "history written outside result stage")

endmodule

// File: bench/rprr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rank and regime checker
// Watches the sample, result and configuration channels and keeps its own
// copy of the window history. Each accepted result word is compared with the
// oldest predicted word.
// ----------------------------------------------------------------------------
module rprr_checker
  import rprr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [31:0]          in_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PCT_W-1:0]     out_rank_q8,
  input  logic [1:0]           out_regime,
  input  logic                 out_window_full,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data,
  output int unsigned          outstanding,
  output int unsigned          fail_count
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [PCT_W-1:0] rank_q8;
    regime_t          regime;
    logic             window_full;
  } rank_word_t;

  logic [31:0]      past_samples [DEPTH];
  logic [7:0]       slot_next;
  logic [8:0]       stored;
  logic [WIN_W-1:0] win_reg;
  logic [PCT_W-1:0] lo_reg;
  logic [PCT_W-1:0] hi_reg;
  rank_word_t       pending_ranks [$];
  int unsigned      errors = 0;

  // Ranks one sample against the previous span-1 samples, then stores it.
  function automatic rank_word_t rank_and_store(input logic [31:0] smp);
    int unsigned span;
    int unsigned prior;
    int unsigned below;
    int unsigned scaled;
    rank_word_t  r;
    span = win_reg;
    if (span < 2) span = 2;
    if (span > DEPTH) span = DEPTH;
    prior = span - 1;
    below = 0;
    for (int unsigned i = 1; i <= prior; i++) begin
      if (past_samples[8'(slot_next - i)] < smp) below++;
    end
    scaled = RANK_FULL * below;
    r.rank_q8 = PCT_W'(scaled / prior);
    // Exact comparison against the unrounded rank; calm wins when crossed.
    if (scaled < lo_reg * prior) r.regime = REGIME_CALM;
    else if (scaled > hi_reg * prior) r.regime = REGIME_VOLATILE;
    else r.regime = REGIME_NORMAL;
    r.window_full = (stored >= prior);
    past_samples[slot_next] = smp;
    slot_next = slot_next + 8'd1;
    if (stored < DEPTH) stored = stored + 9'd1;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rank_word_t want;
    if (!rst_n) begin
      foreach (past_samples[i]) past_samples[i] = '0;
      slot_next = '0;
      stored = '0;
      win_reg = WINDOW_LEN_RST;
      lo_reg = LO_PCT_RST;
      hi_reg = HI_PCT_RST;
      pending_ranks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_ranks.size() == 0) begin
          $display("%0t: result word with nothing expected, got rank %0d regime %0d full %0d",
                   $time, out_rank_q8, out_regime, out_window_full);
          errors++;
        end else begin
          want = pending_ranks.pop_front();
          report_field("rank_q8", want.rank_q8, out_rank_q8);
          report_field("regime", want.regime, out_regime);
          report_field("window_full", want.window_full, out_window_full);
        end
      end
      if (in_valid && !in_stall) pending_ranks.push_back(rank_and_store(in_sample));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_LEN: win_reg = cfg_data[WIN_W-1:0];
          CFG_LO_PCT:     lo_reg = cfg_data;
          CFG_HI_PCT:     hi_reg = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_ranks.size();
    fail_count <= errors;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rolling percentile rank regime testbench
// Drives volatility samples and register writes into the classifier, with
// random gaps and stalls on both channels, while a checker beside the block
// predicts every rank, regime and window-full flag.
// ----------------------------------------------------------------------------
module tb_top;
  import rprr_pkg::*;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  // The long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES  = 1500;
  // Quiet cycles at the end: more than the latency of the widest window.
  localparam int TAIL_CYCLES  = 400;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_sample       = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [PCT_W-1:0]     out_rank_q8;
  logic [1:0]           out_regime;
  logic                 out_window_full;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [PCT_W-1:0]     cfg_data        = '0;

  int unsigned outstanding;
  int unsigned fail_count;

  // Idling odds in percent per cycle. The receiver's is read by its own
  // process, so it is only ever updated with nonblocking assignments.
  int  tx_idle_pct = 35;
  int  rx_idle_pct = 61;
  int  sent        = 0;
  logic hold_go    = 1'b0;
  logic hold_off   = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  rolling_percentile_rank_regime u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank_q8     (out_rank_q8),
    .out_regime      (out_regime),
    .out_window_full (out_window_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  rprr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rank_q8     (out_rank_q8),
    .out_regime      (out_regime),
    .out_window_full (out_window_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .fail_count      (fail_count)
  );

  // The receiver stalls at random, except during the hold-off, when it
  // refuses every result word so that the block backs up into its input.
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // The hold-off counts its own cycles, independent of the sender, which
  // keeps offering samples the whole time.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offers one sample word after a random gap and returns at the edge where
  // it is taken. Valid stays high on return so back-to-back words have no
  // bubble; whoever comes next either lowers it or replaces the payload.
  task automatic send_sample(input logic [31:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // One register write word; valid is left high for a following write.
  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input logic [PCT_W-1:0] win, input logic [PCT_W-1:0] lo,
                              input logic [PCT_W-1:0] hi);
    cfg_word(CFG_WINDOW_LEN, win);
    cfg_word(CFG_LO_PCT, lo);
    cfg_word(CFG_HI_PCT, hi);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted word has come back. The checker's count
  // is registered, hence the first edge before looking at it. Every
  // sample gives a result, so an empty queue means the block is idle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sample mix: full-range values, a narrow band that produces many ties,
  // the extremes, values near the top, and straight repeats.
  function automatic logic [31:0] next_sample(input logic [31:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 15);
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      8:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return prev;
    endcase
  endfunction

  initial begin
    logic [PCT_W-1:0] win;
    logic [PCT_W-1:0] lo;
    logic [PCT_W-1:0] hi;
    logic [31:0]      smp;
    int               base;
    int               phase;
    int               n_items;
    int               pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, history still cleared: the zero slots count as
    // samples below anything nonzero, and the window is far from full.
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    drain();

    // A window of zero acts as two; equal samples never count as below.
    write_config(15'd0, 15'd0, 15'd25600);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd6);
    send_sample(32'd0);
    drain();

    // A window of one acts as two; thresholds above full scale make
    // every rank calm and none volatile.
    write_config(15'd1, 15'h7FFF, 15'h7FFF);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    drain();

    // All-ones window data masks to 511 and clamps to the maximum; the
    // thresholds are crossed so the calm test must win. The write to the
    // unused index in front must change nothing.
    cfg_word(CFG_UNUSED, 15'h5A5A);
    write_config(15'h7FFF, 15'd25600, 15'd0);
    send_sample(32'h0000_0010);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    drain();

    // Window data with bits above the register width: it masks to three.
    // Both thresholds sit on the half-way rank to hit the boundary exactly.
    write_config(15'h0203, 15'd12800, 15'd12800);
    send_sample(32'd10);
    send_sample(32'd20);
    send_sample(32'd15);
    send_sample(32'd15);
    drain();

    // Random phases, each under a fresh setting. Most windows are short so
    // the window fills and wraps often; a few use the widest window.
    base = sent;
    phase = 0;
    smp = '0;
    while (sent - base < RANDOM_ITEMS) begin
      if (sent - base < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 35;
        rx_idle_pct <= 61;
      end else if (sent - base < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 61;
        rx_idle_pct <= 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      pick = $urandom_range(0, 19);
      if (pick < 12) win = PCT_W'($urandom_range(2, 16));
      else if (pick < 15) win = PCT_W'($urandom_range(17, 64));
      else if (pick < 17) win = PCT_W'($urandom_range(0, 1));
      else if (pick < 18) win = PCT_W'($urandom_range(200, 256));
      else if (pick < 19) win = PCT_W'($urandom_range(257, 511));
      else win = PCT_W'($urandom_range(0, 32767));

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        lo = PCT_W'($urandom_range(0, 25600));
        hi = PCT_W'($urandom_range(32'(lo), 25600));
      end else if (pick < 8) begin
        lo = PCT_W'($urandom_range(0, 32767));
        hi = PCT_W'($urandom_range(0, 32767));
      end else if (pick == 8) begin
        lo = 15'd0;
        hi = 15'd25600;
      end else begin
        lo = 15'd25600;
        hi = 15'd0;
      end

      if ($urandom_range(0, 4) == 0) cfg_word(CFG_UNUSED, PCT_W'($urandom_range(0, 32767)));
      write_config(win, lo, hi);

      // One phase carries the long receiver hold-off.
      if (phase == 3) hold_go <= 1'b1;

      n_items = $urandom_range(15, 60);
      repeat (n_items) begin
        smp = next_sample(smp);
        send_sample(smp);
      end
      drain();
      phase++;
    end

    // Anything that turns up now is a stray result word.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** rolling_percentile_rank_regime: PASSED **");
    end else begin
      $display("** rolling_percentile_rank_regime: FAILED **");
    end
    $finish;
  end

  // Several times the slowest correct run: every sample at the widest
  // window with both sides idling, plus the hold-off.
  initial begin
    #5000000;
    $display("** rolling_percentile_rank_regime: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rprr_pkg.sv
hdl/rprr_ram.sv
hdl/rprr_div.sv
hdl/rolling_percentile_rank_regime.sv
bench/rprr_checker.sv
bench/tb_top.sv
